[rtl/rtcseq_pkg.sv]
// Shared types, codes and conversion functions of the clock-chip transfer sequencer.
package rtcseq_pkg;

    localparam int REG_BYTES = 8;
    localparam int IDX_W     = $clog2(REG_BYTES);
    localparam int POS_W     = 4;
    localparam int ADDR_W    = 7;

    localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'b1101000;
    localparam logic [POS_W-1:0]  POS_MAX      = 4'd15;
    localparam logic [POS_W-1:0]  POS_END      = POS_W'(REG_BYTES);
    localparam logic [POS_W-1:0]  POS_LAST     = POS_W'(REG_BYTES - 1);
    localparam logic [7:0]        REG_PTR      = 8'h00;
    localparam logic [7:0]        CTRL_BYTE    = 8'h00;

    // item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BUS   = 2'd2;

    // bus status codes
    localparam logic [2:0] ST_START       = 3'd0;
    localparam logic [2:0] ST_ADDR_W_ACK  = 3'd1;
    localparam logic [2:0] ST_DATA_W_ACK  = 3'd2;
    localparam logic [2:0] ST_REP_START   = 3'd3;
    localparam logic [2:0] ST_ADDR_R_ACK  = 3'd4;
    localparam logic [2:0] ST_DATA_R_ACK  = 3'd5;
    localparam logic [2:0] ST_DATA_R_NACK = 3'd6;

    // bus commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_RX_ACK  = 3'd3;
    localparam logic [2:0] CMD_RX_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;

    // transfer modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] set_seconds;
        logic [6:0] set_minutes;
        logic [6:0] set_hours;
        logic [7:0] set_weekday;
        logic [6:0] set_day;
        logic [6:0] set_month;
        logic [6:0] set_year;
        logic [2:0] bus_status;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] tx_byte;
        logic       request_taken;
        logic       time_valid;
        logic [7:0] got_seconds;
        logic [7:0] got_minutes;
        logic [7:0] got_hours;
        logic [7:0] got_weekday;
        logic [7:0] got_day;
        logic [7:0] got_month;
        logic [7:0] got_year;
        logic       bus_error;
    } t_result;

    // binary to packed BCD, valid for 0..99; divide by 10 via reciprocal multiply
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        r    = v - 7'({3'b000, q} * 7'd10);
        return {q, r[3:0]};
    endfunction

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        return 8'({4'b0000, b[7:4]} * 8'd10) + {4'b0000, b[3:0]};
    endfunction

endpackage

[rtl/rtcseq_item_if.sv]
// Input item channel: requests and bus status events.
interface rtcseq_item_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic [6:0]                       set_seconds;
    logic [6:0]                       set_minutes;
    logic [6:0]                       set_hours;
    logic [7:0]                       set_weekday;
    logic [6:0]                       set_day;
    logic [6:0]                       set_month;
    logic [6:0]                       set_year;
    logic [2:0]                       bus_status;
    logic [7:0]                       rx_byte;

    modport source (
        output valid, opcode, set_seconds, set_minutes, set_hours, set_weekday,
               set_day, set_month, set_year, bus_status, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, set_seconds, set_minutes, set_hours, set_weekday,
               set_day, set_month, set_year, bus_status, rx_byte,
        output ready
    );
endinterface

[rtl/rtcseq_result_if.sv]
// Result item channel: bus command, decoded time and status flags.
interface rtcseq_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       request_taken;
    logic       time_valid;
    logic [7:0] got_seconds;
    logic [7:0] got_minutes;
    logic [7:0] got_hours;
    logic [7:0] got_weekday;
    logic [7:0] got_day;
    logic [7:0] got_month;
    logic [7:0] got_year;
    logic       bus_error;

    modport source (
        output valid, bus_command, tx_byte, request_taken, time_valid, got_seconds,
               got_minutes, got_hours, got_weekday, got_day, got_month, got_year,
               bus_error,
        input  ready
    );
    modport sink (
        input  valid, bus_command, tx_byte, request_taken, time_valid, got_seconds,
               got_minutes, got_hours, got_weekday, got_day, got_month, got_year,
               bus_error,
        output ready
    );
endinterface

[rtl/rtcseq_cfg_if.sv]
// Configuration write channel carrying the device address.
interface rtcseq_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/rtcseq_in_stage.sv]
// Input register stage: captures one item and holds it until the decision stage takes it.
module rtcseq_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rtcseq_item_if.sink          i_item,
    input  logic                 i_take,
    output logic                 o_valid,
    output rtcseq_pkg::t_item    o_item
);
    import rtcseq_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign i_item.ready = !r_valid || i_take;
    assign load         = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.opcode      <= i_item.opcode;
            r_item.set_seconds <= i_item.set_seconds;
            r_item.set_minutes <= i_item.set_minutes;
            r_item.set_hours   <= i_item.set_hours;
            r_item.set_weekday <= i_item.set_weekday;
            r_item.set_day     <= i_item.set_day;
            r_item.set_month   <= i_item.set_month;
            r_item.set_year    <= i_item.set_year;
            r_item.bus_status  <= i_item.bus_status;
            r_item.rx_byte     <= i_item.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/rtcseq_ctrl.sv]
// Transfer control: mode, byte position and clock byte buffer, plus the per-item decision.
module rtcseq_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  rtcseq_pkg::t_item                 i_item,
    input  logic [rtcseq_pkg::ADDR_W-1:0]     i_dev_addr,
    output rtcseq_pkg::t_result               o_result
);
    import rtcseq_pkg::*;

    logic [1:0]       r_mode;
    logic [1:0]       n_mode;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_bytes [REG_BYTES];
    logic [7:0]       n_bytes [REG_BYTES];
    logic [POS_W-1:0] pos_inc;
    t_result          res;

    assign pos_inc = (r_pos < POS_MAX) ? r_pos + 1'b1 : r_pos;

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_bytes = r_bytes;
        res     = '0;
        case (i_item.opcode)
            OP_WRITE: begin
                if (r_mode == MODE_IDLE) begin
                    n_bytes[0] = bin_to_bcd(i_item.set_seconds);
                    n_bytes[1] = bin_to_bcd(i_item.set_minutes);
                    n_bytes[2] = bin_to_bcd(i_item.set_hours);
                    n_bytes[3] = i_item.set_weekday;
                    n_bytes[4] = bin_to_bcd(i_item.set_day);
                    n_bytes[5] = bin_to_bcd(i_item.set_month);
                    n_bytes[6] = bin_to_bcd(i_item.set_year);
                    n_bytes[7] = CTRL_BYTE;
                    n_mode            = MODE_WRITE;
                    res.bus_command   = CMD_START;
                    res.request_taken = 1'b1;
                end
            end
            OP_READ: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode            = MODE_READ;
                    res.bus_command   = CMD_START;
                    res.request_taken = 1'b1;
                end
            end
            OP_BUS: begin
                case (i_item.bus_status)
                    ST_START: begin
                        res.bus_command = CMD_SEND;
                        res.tx_byte     = {i_dev_addr, 1'b0};
                        n_pos           = '0;
                    end
                    ST_ADDR_W_ACK: begin
                        res.bus_command = CMD_SEND;
                        res.tx_byte     = REG_PTR;
                    end
                    ST_DATA_W_ACK: begin
                        if (r_mode == MODE_WRITE) begin
                            if (r_pos < POS_END) begin
                                res.bus_command = CMD_SEND;
                                res.tx_byte     = r_bytes[r_pos[IDX_W-1:0]];
                                n_pos           = r_pos + 1'b1;
                            end else begin
                                res.bus_command = CMD_STOP;
                                n_mode          = MODE_IDLE;
                            end
                        end else if (r_mode == MODE_READ) begin
                            res.bus_command = CMD_START;
                        end
                    end
                    ST_REP_START: begin
                        res.bus_command = CMD_SEND;
                        res.tx_byte     = {i_dev_addr, 1'b1};
                    end
                    ST_ADDR_R_ACK: begin
                        res.bus_command = CMD_RX_ACK;
                    end
                    ST_DATA_R_ACK: begin
                        if (r_pos < POS_END) begin
                            n_bytes[r_pos[IDX_W-1:0]] = i_item.rx_byte;
                        end
                        n_pos           = pos_inc;
                        res.bus_command = (pos_inc < POS_LAST) ? CMD_RX_ACK : CMD_RX_NACK;
                    end
                    ST_DATA_R_NACK: begin
                        if (r_pos < POS_END) begin
                            n_bytes[r_pos[IDX_W-1:0]] = i_item.rx_byte;
                        end
                        res.bus_command = CMD_STOP;
                        n_mode          = MODE_IDLE;
                        res.time_valid  = 1'b1;
                        // decode sees the byte stored by this same item
                        res.got_seconds = bcd_to_bin(n_bytes[0]);
                        res.got_minutes = bcd_to_bin(n_bytes[1]);
                        res.got_hours   = bcd_to_bin(n_bytes[2]);
                        res.got_weekday = n_bytes[3];
                        res.got_day     = bcd_to_bin(n_bytes[4]);
                        res.got_month   = bcd_to_bin(n_bytes[5]);
                        res.got_year    = bcd_to_bin(n_bytes[6]);
                    end
                    default: begin
                        res.bus_command = CMD_STOP;
                        n_mode          = MODE_IDLE;
                        res.bus_error   = 1'b1;
                    end
                endcase
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos  <= '0;
            for (int i = 0; i < REG_BYTES; i++) begin
                r_bytes[i] <= '0;
            end
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_bytes <= n_bytes;
        end
    end

    assign o_result = res;

endmodule

[rtl/rtc_i2c_time_transfer_sequencer.sv]
// Real-time-clock transfer sequencer: I2C master command sequencing for the clock's time registers.
//
// Accepts one item per clock cycle: write requests (time fields but the weekday are BCD-encoded
// into an eight-byte buffer), read requests, and bus status events; every item yields exactly one
// result carrying the next bus command, the byte to send, and on the final read NACK the
// decoded time. An item passes through an input register and one decision stage into the
// result register, from which its result is presented on the result channel. Throughput
// is one item per cycle while the result side keeps up. A waiting result holds the next item
// in the input register, and the input stalls once that register is full.
// Requests while a transfer is in progress yield an all-zero result; an unknown
// bus status issues a stop and flags bus_error. The device address is written through the
// configuration channel, which is always ready, and resets to 0x68.
module rtc_i2c_time_transfer_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtcseq_item_if.sink       i_item,
    rtcseq_result_if.source   o_result,
    rtcseq_cfg_if.sink        i_cfg
);
    import rtcseq_pkg::*;

    logic [ADDR_W-1:0] r_dev_addr;
    logic              stage_valid;
    t_item             stage_item;
    logic              out_free;
    logic              fire;
    t_result           next_result;
    logic              r_out_valid;
    t_result           r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
        end else if (i_cfg.valid) begin
            r_dev_addr <= i_cfg.data;
        end
    end

    rtcseq_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (fire),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    assign out_free = !r_out_valid || o_result.ready;
    assign fire     = stage_valid && out_free;

    rtcseq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_item     (stage_item),
        .i_dev_addr (r_dev_addr),
        .o_result   (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= next_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.bus_command   = r_out.bus_command;
    assign o_result.tx_byte       = r_out.tx_byte;
    assign o_result.request_taken = r_out.request_taken;
    assign o_result.time_valid    = r_out.time_valid;
    assign o_result.got_seconds   = r_out.got_seconds;
    assign o_result.got_minutes   = r_out.got_minutes;
    assign o_result.got_hours     = r_out.got_hours;
    assign o_result.got_weekday   = r_out.got_weekday;
    assign o_result.got_day       = r_out.got_day;
    assign o_result.got_month     = r_out.got_month;
    assign o_result.got_year      = r_out.got_year;
    assign o_result.bus_error     = r_out.bus_error;

endmodule

[sim/rtcseq_checker.sv]
// Scoreboard for the clock-chip transfer sequencer: predicts each result and compares.
`timescale 1ns / 100ps

module rtcseq_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rtcseq_item_if   i_item,
    rtcseq_result_if i_result,
    rtcseq_cfg_if    i_cfg,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_reads_decoded,
    output int       o_aborts
);
    import rtcseq_pkg::*;

    localparam int BUF_BYTES  = REG_BYTES;
    localparam int PRINT_CAP  = 100;

    logic [ADDR_W-1:0] dev_addr;
    logic [1:0]        xfer_mode;
    logic [POS_W-1:0]  byte_pos;
    logic [7:0]        clock_regs [BUF_BYTES];

    t_result expected_results [$];
    int      fails;
    int      results_seen;
    int      reads_decoded;
    int      aborts;

    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        int n;
        n = int'(v);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
    endfunction

    // advances the shadow sequencer by one item and returns the result it produces
    function automatic t_result next_bus_result(input t_item it);
        t_result r;
        r = '0;
        case (it.opcode)
            OP_WRITE: begin
                if (xfer_mode == MODE_IDLE) begin
                    clock_regs[0] = to_bcd(it.set_seconds);
                    clock_regs[1] = to_bcd(it.set_minutes);
                    clock_regs[2] = to_bcd(it.set_hours);
                    clock_regs[3] = it.set_weekday;
                    clock_regs[4] = to_bcd(it.set_day);
                    clock_regs[5] = to_bcd(it.set_month);
                    clock_regs[6] = to_bcd(it.set_year);
                    clock_regs[7] = CTRL_BYTE;
                    xfer_mode       = MODE_WRITE;
                    r.bus_command   = CMD_START;
                    r.request_taken = 1'b1;
                end
            end
            OP_READ: begin
                if (xfer_mode == MODE_IDLE) begin
                    xfer_mode       = MODE_READ;
                    r.bus_command   = CMD_START;
                    r.request_taken = 1'b1;
                end
            end
            OP_BUS: begin
                case (it.bus_status)
                    ST_START: begin
                        r.bus_command = CMD_SEND;
                        r.tx_byte     = {dev_addr, 1'b0};
                        byte_pos      = '0;
                    end
                    ST_ADDR_W_ACK: begin
                        r.bus_command = CMD_SEND;
                        r.tx_byte     = REG_PTR;
                    end
                    ST_DATA_W_ACK: begin
                        if (xfer_mode == MODE_WRITE) begin
                            if (int'(byte_pos) < BUF_BYTES) begin
                                r.bus_command = CMD_SEND;
                                r.tx_byte     = clock_regs[byte_pos];
                                byte_pos      = byte_pos + 1'b1;
                            end else begin
                                r.bus_command = CMD_STOP;
                                xfer_mode     = MODE_IDLE;
                            end
                        end else if (xfer_mode == MODE_READ) begin
                            // repeated start toward the read address
                            r.bus_command = CMD_START;
                        end
                    end
                    ST_REP_START: begin
                        r.bus_command = CMD_SEND;
                        r.tx_byte     = {dev_addr, 1'b1};
                    end
                    ST_ADDR_R_ACK: begin
                        r.bus_command = CMD_RX_ACK;
                    end
                    ST_DATA_R_ACK: begin
                        if (int'(byte_pos) < BUF_BYTES) clock_regs[byte_pos] = it.rx_byte;
                        if (byte_pos < POS_MAX) byte_pos = byte_pos + 1'b1;
                        r.bus_command = (int'(byte_pos) < BUF_BYTES - 1) ? CMD_RX_ACK
                                                                         : CMD_RX_NACK;
                    end
                    ST_DATA_R_NACK: begin
                        if (int'(byte_pos) < BUF_BYTES) clock_regs[byte_pos] = it.rx_byte;
                        r.bus_command = CMD_STOP;
                        xfer_mode     = MODE_IDLE;
                        r.time_valid  = 1'b1;
                        r.got_seconds = from_bcd(clock_regs[0]);
                        r.got_minutes = from_bcd(clock_regs[1]);
                        r.got_hours   = from_bcd(clock_regs[2]);
                        r.got_weekday = clock_regs[3];
                        r.got_day     = from_bcd(clock_regs[4]);
                        r.got_month   = from_bcd(clock_regs[5]);
                        r.got_year    = from_bcd(clock_regs[6]);
                    end
                    default: begin
                        r.bus_command = CMD_STOP;
                        xfer_mode     = MODE_IDLE;
                        r.bus_error   = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= PRINT_CAP) $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            dev_addr  = DEV_ADDR_RST;
            xfer_mode = MODE_IDLE;
            byte_pos  = '0;
            for (int k = 0; k < BUF_BYTES; k++) clock_regs[k] = '0;
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.bus_command   = i_result.bus_command;
                got.tx_byte       = i_result.tx_byte;
                got.request_taken = i_result.request_taken;
                got.time_valid    = i_result.time_valid;
                got.got_seconds   = i_result.got_seconds;
                got.got_minutes   = i_result.got_minutes;
                got.got_hours     = i_result.got_hours;
                got.got_weekday   = i_result.got_weekday;
                got.got_day       = i_result.got_day;
                got.got_month     = i_result.got_month;
                got.got_year      = i_result.got_year;
                got.bus_error     = i_result.bus_error;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_results.pop_front();
                    check_field("bus_command", 8'(got.bus_command), 8'(want.bus_command));
                    check_field("tx_byte", got.tx_byte, want.tx_byte);
                    check_field("request_taken", 8'(got.request_taken),
                                8'(want.request_taken));
                    check_field("time_valid", 8'(got.time_valid), 8'(want.time_valid));
                    check_field("got_seconds", got.got_seconds, want.got_seconds);
                    check_field("got_minutes", got.got_minutes, want.got_minutes);
                    check_field("got_hours", got.got_hours, want.got_hours);
                    check_field("got_weekday", got.got_weekday, want.got_weekday);
                    check_field("got_day", got.got_day, want.got_day);
                    check_field("got_month", got.got_month, want.got_month);
                    check_field("got_year", got.got_year, want.got_year);
                    check_field("bus_error", 8'(got.bus_error), 8'(want.bus_error));
                end
                results_seen++;
            end
            // address writes happen only with the pipeline empty
            if (i_cfg.valid && i_cfg.ready) dev_addr = i_cfg.data;
            if (i_item.valid && i_item.ready) begin
                it.opcode      = i_item.opcode;
                it.set_seconds = i_item.set_seconds;
                it.set_minutes = i_item.set_minutes;
                it.set_hours   = i_item.set_hours;
                it.set_weekday = i_item.set_weekday;
                it.set_day     = i_item.set_day;
                it.set_month   = i_item.set_month;
                it.set_year    = i_item.set_year;
                it.bus_status  = i_item.bus_status;
                it.rx_byte     = i_item.rx_byte;
                want = next_bus_result(it);
                if (want.time_valid) reads_decoded++;
                if (want.bus_error) aborts++;
                expected_results.push_back(want);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_results.size();
        o_reads_decoded <= reads_decoded;
        o_aborts        <= aborts;
    end

endmodule

[sim/rtc_i2c_time_transfer_sequencer_tb.sv]
// Testbench top for the clock-chip transfer sequencer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module rtc_i2c_time_transfer_sequencer_tb;
    import rtcseq_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [2:0] ST_OTHER    = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASES      = 5;
    localparam int         PHASE_ITEMS = 280;

    logic clk;
    logic rst_n;

    rtcseq_item_if   item_ch ();
    rtcseq_result_if result_ch ();
    rtcseq_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int reads_decoded;
    int aborts;

    int items_sent;
    int addr_settings;
    int src_idle_pct;
    int sink_stall_pct;
    int holds_asked;
    int holds_served;
    int quiet_cycles;

    rtc_i2c_time_transfer_sequencer u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    rtcseq_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_item          (item_ch),
        .i_result        (result_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_reads_decoded (reads_decoded),
        .o_aborts        (aborts)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // all fields random, including the ones the block ignores for this item
    function automatic t_item rand_fields();
        t_item it;
        it.opcode      = 2'($urandom_range(3));
        it.set_seconds = 7'($urandom_range(127));
        it.set_minutes = 7'($urandom_range(127));
        it.set_hours   = 7'($urandom_range(127));
        it.set_weekday = 8'($urandom_range(255));
        it.set_day     = 7'($urandom_range(127));
        it.set_month   = 7'($urandom_range(127));
        it.set_year    = 7'($urandom_range(127));
        it.bus_status  = 3'($urandom_range(7));
        it.rx_byte     = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic t_item time_request(input logic [1:0] op);
        t_item it;
        it = rand_fields();
        it.opcode = op;
        // mostly in-range time values, now and then the full field width
        if ($urandom_range(9) != 0) begin
            it.set_seconds = 7'($urandom_range(99));
            it.set_minutes = 7'($urandom_range(99));
            it.set_hours   = 7'($urandom_range(99));
            it.set_day     = 7'($urandom_range(99));
            it.set_month   = 7'($urandom_range(99));
            it.set_year    = 7'($urandom_range(99));
        end
        return it;
    endfunction

    function automatic t_item bus_event(input logic [2:0] st);
        t_item it;
        it = rand_fields();
        it.opcode     = OP_BUS;
        it.bus_status = st;
        if ($urandom_range(9) < 6)
            it.rx_byte = {4'($urandom_range(9)), 4'($urandom_range(9))};
        return it;
    endfunction

    task automatic put_item(input t_item it);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= it.opcode;
        item_ch.set_seconds <= it.set_seconds;
        item_ch.set_minutes <= it.set_minutes;
        item_ch.set_hours   <= it.set_hours;
        item_ch.set_weekday <= it.set_weekday;
        item_ch.set_day     <= it.set_day;
        item_ch.set_month   <= it.set_month;
        item_ch.set_year    <= it.set_year;
        item_ch.bus_status  <= it.bus_status;
        item_ch.rx_byte     <= it.rx_byte;
        do @(posedge clk); while (!item_ch.ready);
        if (it.opcode != OP_SPARE) items_sent++;
    endtask

    task automatic write_transfer(input int data_acks);
        put_item(time_request(OP_WRITE));
        put_item(bus_event(ST_START));
        put_item(bus_event(ST_ADDR_W_ACK));
        repeat (data_acks) put_item(bus_event(ST_DATA_W_ACK));
    endtask

    // a read that ends in the final NACK, or is cut off by an unknown status
    task automatic read_transfer(input int data_reads, input bit finish);
        put_item(time_request(OP_READ));
        put_item(bus_event(ST_START));
        put_item(bus_event(ST_ADDR_W_ACK));
        put_item(bus_event(ST_DATA_W_ACK));
        put_item(bus_event(ST_REP_START));
        put_item(bus_event(ST_ADDR_R_ACK));
        repeat (data_reads) put_item(bus_event(ST_DATA_R_ACK));
        put_item(bus_event(finish ? ST_DATA_R_NACK : ST_OTHER));
    endtask

    task automatic run_random(input int target);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < target) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                write_transfer(REG_BYTES + 1);
            end else if (pick < 70) begin
                read_transfer(REG_BYTES - 1, 1'b1);
            end else if (pick < 78) begin
                // runs the position past the buffer, up to saturation
                read_transfer($urandom_range(REG_BYTES, 16), 1'b1);
            end else if (pick < 86) begin
                write_transfer($urandom_range(0, REG_BYTES));
                put_item(bus_event(ST_OTHER));
            end else if (pick < 92) begin
                read_transfer($urandom_range(0, 6), 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) put_item(rand_fields());
            end
        end
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_device_address(input logic [ADDR_W-1:0] a);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= a;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        addr_settings++;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("rtc_i2c_time_transfer_sequencer verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_item it;
        logic [ADDR_W-1:0] phase_addr [PHASES];
        int src_pct  [PHASES];
        int sink_pct [PHASES];

        phase_addr = '{7'h7F, 7'h00, 7'($urandom_range(127)), 7'($urandom_range(127)),
                       7'($urandom_range(127))};
        src_pct  = '{0, 68, 0, 33, 0};
        sink_pct = '{0, 0, 68, 33, 0};

        items_sent     = 0;
        addr_settings  = 1;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holds_asked    = 0;
        holds_served   = 0;

        item_ch.valid       = 1'b0;
        item_ch.opcode      = '0;
        item_ch.set_seconds = '0;
        item_ch.set_minutes = '0;
        item_ch.set_hours   = '0;
        item_ch.set_weekday = '0;
        item_ch.set_day     = '0;
        item_ch.set_month   = '0;
        item_ch.set_year    = '0;
        item_ch.bus_status  = '0;
        item_ch.rx_byte     = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes on the reset address, busy request, idle data ack,
        // spare opcode, a short read decoded on NACK, then an abort
        it = time_request(OP_WRITE);
        it.set_seconds = 7'd0;
        it.set_minutes = 7'd99;
        it.set_hours   = 7'd127;
        it.set_weekday = 8'hFF;
        it.set_day     = 7'd1;
        it.set_month   = 7'd12;
        it.set_year    = 7'd99;
        put_item(it);
        put_item(bus_event(ST_START));
        put_item(bus_event(ST_ADDR_W_ACK));
        put_item(time_request(OP_READ));
        repeat (REG_BYTES + 1) put_item(bus_event(ST_DATA_W_ACK));
        put_item(bus_event(ST_DATA_W_ACK));
        it = rand_fields();
        it.opcode = OP_SPARE;
        put_item(it);
        read_transfer(2, 1'b1);
        put_item(bus_event(ST_OTHER));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            write_device_address(phase_addr[ph]);
            run_random(PHASE_ITEMS);
            drain();
        end

        // back-pressure: output held off while the input keeps offering items
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_device_address(7'($urandom_range(127)));
        holds_asked++;
        run_random(80);
        drain();

        repeat (8) @(posedge clk);

        $display("covered %0d items over %0d address settings, idle/stall mixes and a long hold",
                 items_sent, addr_settings);
        $display("%0d reads decoded, %0d transfers aborted, %0d mismatches",
                 reads_decoded, aborts, fail_count);
        if (fail_count == 0) begin
            $display("rtc_i2c_time_transfer_sequencer verification clean");
        end else begin
            $display("rtc_i2c_time_transfer_sequencer verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rtcseq_pkg.sv
rtl/rtcseq_item_if.sv
rtl/rtcseq_result_if.sv
rtl/rtcseq_cfg_if.sv
rtl/rtcseq_in_stage.sv
rtl/rtcseq_ctrl.sv
rtl/rtc_i2c_time_transfer_sequencer.sv
sim/rtcseq_checker.sv
sim/rtc_i2c_time_transfer_sequencer_tb.sv
